[src/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[src/edt_pkg.sv]
package edt_pkg;

    // longest target and source word
    localparam int MAX_LEN = 64;
    // row memory and target memory address width
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    // width of counts and row costs, which never exceed MAX_LEN
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int CHAR_W  = 8;
    localparam int DIST_W  = 7;
    localparam int OP_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SOURCE = 2'd2,
        OP_END    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINAL
    } t_state;

endpackage

[src/edt_ram.sv]
module edt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/edt_cell.sv]
module edt_cell (
    input  logic                    i_match,
    input  logic [edt_pkg::CNT_W-1:0] i_diag,
    input  logic [edt_pkg::CNT_W-1:0] i_up,
    input  logic [edt_pkg::CNT_W-1:0] i_left,
    output logic [edt_pkg::CNT_W-1:0] o_cost
);

    import edt_pkg::*;

    logic [CNT_W-1:0] min_ul;
    logic [CNT_W-1:0] min_all;

    // true three-way minimum of insertion, deletion and substitution
    always_comb begin
        min_ul  = (i_up < i_left) ? i_up : i_left;
        min_all = (i_diag < min_ul) ? i_diag : min_ul;
        o_cost  = i_match ? i_diag : CNT_W'(min_all + CNT_W'(1));
    end

endmodule

[src/edit_distance_engine_unit.sv]
// Levenshtein edit distance with unit costs against a stored target word of up
// to MAX_LEN bytes. Op 0 clears the target, op 1 appends i_ch to it, op 2 feeds
// i_ch as the next source character, op 3 ends the source word and produces one
// result (distance and overflow flag) on o_valid in the cycle after the FINAL
// state; the receiver cannot stall, so the result must be captured in that
// cycle. Ops 0 and 1 leave busy low. Op 2 scans the row in the SCAN state:
// one row cell per cycle through the single cost cell and the row memory's
// read/write port pair (busy stays low when the target is empty or the
// character is dropped). Op 3 passes through the FINAL state for the row memory
// read. Items are taken while start is high and busy is low.
`include "assert_macros.svh"

module edit_distance_engine_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [edt_pkg::OP_W-1:0]   i_op,
    input  logic [edt_pkg::CHAR_W-1:0] i_ch,
    output logic                       o_valid,
    output logic [edt_pkg::DIST_W-1:0] o_distance,
    output logic                       o_overflow
);

    import edt_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_tlen, n_tlen;
    logic [CNT_W-1:0]    r_scnt, n_scnt;
    logic                r_ovf, n_ovf;
    logic [MAX_LEN-1:0]  r_valid, n_valid;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]    r_diag, n_diag;
    logic [CNT_W-1:0]    r_left, n_left;
    logic                r_rd_vld;
    logic                r_out_vld, n_out_vld;
    logic [DIST_W-1:0]   r_dist, n_dist;
    logic                r_out_ovf, n_out_ovf;
    logic [CHAR_W-1:0]   r_ch_hold;

    logic                accept;
    t_op                 op;
    logic [ADDR_W-1:0]   rd_addr;
    logic                tgt_we;
    logic                row_we;
    logic [CHAR_W-1:0]   tgt_rdata;
    logic [CNT_W-1:0]    row_rdata;
    logic [CNT_W-1:0]    up;
    logic [CNT_W-1:0]    cost;
    logic [CNT_W-1:0]    next_pos;
    logic                last_cell;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign op     = t_op'(i_op);

    // target characters
    edt_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (tgt_we),
        .i_waddr (r_tlen[ADDR_W-1:0]),
        .i_wdata (i_ch),
        .i_raddr (rd_addr),
        .o_rdata (tgt_rdata)
    );

    // cost row entries 1..MAX_LEN, entry j at address j-1
    edt_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_idx),
        .i_wdata (cost),
        .i_raddr (rd_addr),
        .o_rdata (row_rdata)
    );

    // an entry not written since the last row reset reads as its position
    assign next_pos  = CNT_W'(r_idx) + CNT_W'(1);
    assign up        = r_rd_vld ? row_rdata : next_pos;
    assign last_cell = (next_pos == r_tlen);

    edt_cell u_cell (
        .i_match (tgt_rdata == r_ch_hold),
        .i_diag  (r_diag),
        .i_up    (up),
        .i_left  (r_left),
        .o_cost  (cost)
    );

    // source character held for the row scan
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch_hold <= i_ch;
        end
    end

    // read address for the row and target memories
    always_comb begin
        rd_addr = '0;
        if (r_state == ST_IDLE) begin
            if (op == OP_END) begin
                rd_addr = ADDR_W'(r_tlen - CNT_W'(1));
            end
        end else if (r_state == ST_SCAN && !last_cell) begin
            rd_addr = ADDR_W'(next_pos);
        end
    end

    // sequencer: next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_tlen    = r_tlen;
        n_scnt    = r_scnt;
        n_ovf     = r_ovf;
        n_valid   = r_valid;
        n_idx     = r_idx;
        n_diag    = r_diag;
        n_left    = r_left;
        n_out_vld = 1'b0;
        n_dist    = r_dist;
        n_out_ovf = r_out_ovf;
        tgt_we    = 1'b0;
        row_we    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_CLEAR: begin
                            n_tlen  = '0;
                            n_ovf   = 1'b0;
                            n_valid = '0;
                            n_scnt  = '0;
                        end
                        OP_APPEND: begin
                            if (r_tlen < CNT_W'(MAX_LEN)) begin
                                tgt_we = 1'b1;
                                n_tlen = r_tlen + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                            n_valid = '0;
                            n_scnt  = '0;
                        end
                        OP_SOURCE: begin
                            if (r_scnt < CNT_W'(MAX_LEN)) begin
                                if (r_tlen == '0) begin
                                    n_scnt = r_scnt + CNT_W'(1);
                                end else begin
                                    n_idx   = '0;
                                    n_diag  = r_scnt;
                                    n_left  = r_scnt + CNT_W'(1);
                                    n_state = ST_SCAN;
                                end
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        OP_END: begin
                            n_state = ST_FINAL;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // one row cell per cycle
                row_we              = 1'b1;
                n_valid[r_idx]      = 1'b1;
                n_left              = cost;
                n_diag              = up;
                if (last_cell) begin
                    n_scnt  = r_scnt + CNT_W'(1);
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            ST_FINAL: begin
                n_out_vld = 1'b1;
                if (r_tlen == '0) begin
                    n_dist = DIST_W'(r_scnt);
                end else if (r_rd_vld) begin
                    n_dist = DIST_W'(row_rdata);
                end else begin
                    n_dist = DIST_W'(r_tlen);
                end
                n_out_ovf = r_ovf;
                n_ovf     = 1'b0;
                n_valid   = '0;
                n_scnt    = '0;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_tlen    <= '0;
            r_scnt    <= '0;
            r_ovf     <= 1'b0;
            r_valid   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tlen    <= n_tlen;
            r_scnt    <= n_scnt;
            r_ovf     <= n_ovf;
            r_valid   <= n_valid;
            r_rd_vld  <= r_valid[rd_addr];
            r_out_vld <= n_out_vld;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_diag    <= n_diag;
        r_left    <= n_left;
        r_dist    <= n_dist;
        r_out_ovf <= n_out_ovf;
    end

    assign o_valid    = r_out_vld;
    assign o_distance = r_dist;
    assign o_overflow = r_out_ovf;

    // checks
    `ASSERT_PROP(a_result_after_final, i_clk, i_rst_n, o_valid |-> $past(r_state == ST_FINAL))
    `ASSERT_PROP(a_scan_in_target, i_clk, i_rst_n, (r_state == ST_SCAN) |-> (next_pos <= r_tlen))
    `ASSERT_NEVER(a_scnt_bound, i_clk, i_rst_n, r_scnt > CNT_W'(MAX_LEN))
    `ASSERT_NEVER(a_tlen_bound, i_clk, i_rst_n, r_tlen > CNT_W'(MAX_LEN))

endmodule

[verif/tb.sv]
module tb;
    import edt_pkg::*;

    // one directed step, repeated rep times; typed rows carry their own result
    typedef struct packed {
        t_op              op;
        logic [CHAR_W-1:0] ch;
        logic [7:0]        rep;
        logic              typed;
        logic [DIST_W-1:0] dist_val;
        logic              ovf;
    } t_dir_row;

    typedef struct packed {
        logic [DIST_W-1:0] dist_val;
        logic              ovf;
    } t_dist_res;

    localparam int DIR_ROWS   = 26;
    localparam int ITEM_GOAL  = 1800;
    localparam int IDLE_LIMIT = 3000;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              start    = 1'b0;
    logic [OP_W-1:0]   i_op     = OP_CLEAR;
    logic [CHAR_W-1:0] i_ch     = '0;
    logic              busy;
    logic              o_valid;
    logic [DIST_W-1:0] o_distance;
    logic              o_overflow;

    // predictor state: stored target word and the current cost row
    logic [CHAR_W-1:0] tgt_chars [MAX_LEN];
    int                tgt_len;
    int                dist_row [MAX_LEN+1];
    int                src_len;
    logic              drop_seen;

    t_dist_res dist_expect_q [$];
    t_dist_res dist_head;
    t_dir_row  dir_tab [DIR_ROWS];
    int        mismatch_count = 0;
    int        items_sent = 0;
    int        burst_left = 0;
    int        idle_cycles = 0;

    edit_distance_engine_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_op       (i_op),
        .i_ch       (i_ch),
        .o_valid    (o_valid),
        .o_distance (o_distance),
        .o_overflow (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // back to 0..m and a fresh source word
    task automatic row_init();
        for (int j = 0; j <= MAX_LEN; j++) begin
            dist_row[j] = j;
        end
        src_len = 0;
    endtask

    // levenshtein row update per item; end of word yields the distance
    task automatic edit_predict(input t_op op, input logic [CHAR_W-1:0] ch,
                                output bit has_res, output t_dist_res res);
        int diag;
        int up;
        int val;
        has_res = 1'b0;
        res     = '0;
        case (op)
            OP_CLEAR: begin
                tgt_len   = 0;
                drop_seen = 1'b0;
                row_init();
            end
            OP_APPEND: begin
                if (tgt_len < MAX_LEN) begin
                    tgt_chars[tgt_len] = ch;
                    tgt_len++;
                end else begin
                    drop_seen = 1'b1;
                end
                row_init();
            end
            OP_SOURCE: begin
                if (src_len < MAX_LEN) begin
                    diag        = dist_row[0];
                    dist_row[0] = src_len + 1;
                    for (int j = 1; j <= tgt_len; j++) begin
                        up = dist_row[j];
                        if (tgt_chars[j-1] == ch) begin
                            val = diag;
                        end else begin
                            val = up;
                            if (dist_row[j-1] < val) val = dist_row[j-1];
                            if (diag < val) val = diag;
                            val = val + 1;
                        end
                        diag        = up;
                        dist_row[j] = val;
                    end
                    src_len++;
                end else begin
                    drop_seen = 1'b1;
                end
            end
            default: begin
                has_res      = 1'b1;
                res.dist_val = dist_row[tgt_len][DIST_W-1:0];
                res.ovf      = drop_seen;
                drop_seen    = 1'b0;
                row_init();
            end
        endcase
    endtask

    // present one item, wait for the handshake, predict, then maybe idle
    task automatic send_item(input t_op op, input logic [CHAR_W-1:0] ch,
                             input bit typed, input t_dist_res typed_res);
        bit        has_res;
        t_dist_res res;
        int        gap;
        start <= 1'b1;
        i_op  <= op;
        i_ch  <= ch;
        do @(posedge i_clk); while (busy);
        items_sent++;
        edit_predict(op, ch, has_res, res);
        if (has_res) begin
            dist_expect_q.push_back(typed ? typed_res : res);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(0, 24);
        end
    endtask

    // hold the sender off until every pending distance has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (dist_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // word length: mostly short, sometimes long, rarely near or past the limit
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(0, 8);
        if (r < 97) return $urandom_range(9, 40);
        return $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
    endfunction

    // source char: often one of the target's, else a small alphabet or any byte
    function automatic logic [CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 9);
        if (tgt_len > 0 && r < 5) return tgt_chars[$urandom_range(0, tgt_len - 1)];
        if (r < 8) return CHAR_W'(8'h61 + $urandom_range(0, 3));
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (dist_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result, distance %0d", o_distance));
            end else begin
                dist_head = dist_expect_q.pop_front();
                if (o_distance !== dist_head.dist_val) begin
                    report_mismatch($sformatf("distance %0d, expected %0d",
                                              o_distance, dist_head.dist_val));
                end
                if (o_overflow !== dist_head.ovf) begin
                    report_mismatch($sformatf("overflow %0b, expected %0b",
                                              o_overflow, dist_head.ovf));
                end
            end
        end
    end

    // watchdog on cycles where no item and no result moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        t_dist_res no_res;
        int        len;
        int        r;
        no_res = '0;
        dir_tab = '{
            '{OP_END,    8'h00, 8'd1,  1'b1, 7'd0,  1'b0},  // fresh reset, empty words
            '{OP_SOURCE, 8'h61, 8'd1,  1'b0, 7'd0,  1'b0},
            '{OP_END,    8'h00, 8'd1,  1'b1, 7'd1,  1'b0},  // one char vs empty target
            '{OP_APPEND, 8'h00, 8'd1,  1'b0, 7'd0,  1'b0},
            '{OP_APPEND, 8'hFF, 8'd1,  1'b0, 7'd0,  1'b0},
            '{OP_APPEND, 8'h80, 8'd1,  1'b0, 7'd0,  1'b0},
            '{OP_END,    8'h00, 8'd1,  1'b1, 7'd3,  1'b0},  // empty source word
            '{OP_SOURCE, 8'hFF, 8'd1,  1'b0, 7'd0,  1'b0},
            '{OP_SOURCE, 8'h7F, 8'd1,  1'b0, 7'd0,  1'b0},
            '{OP_END,    8'h00, 8'd1,  1'b0, 7'd0,  1'b0},
            '{OP_SOURCE, 8'h00, 8'd1,  1'b0, 7'd0,  1'b0},
            '{OP_APPEND, 8'h55, 8'd1,  1'b0, 7'd0,  1'b0},  // append drops the word
            '{OP_SOURCE, 8'h80, 8'd1,  1'b0, 7'd0,  1'b0},
            '{OP_END,    8'hFF, 8'd1,  1'b0, 7'd0,  1'b0},
            '{OP_CLEAR,  8'hAA, 8'd1,  1'b0, 7'd0,  1'b0},
            '{OP_END,    8'h00, 8'd1,  1'b1, 7'd0,  1'b0},
            '{OP_APPEND, 8'hFF, 8'd64, 1'b0, 7'd0,  1'b0},  // fill the target
            '{OP_APPEND, 8'h01, 8'd1,  1'b0, 7'd0,  1'b0},  // target full, dropped
            '{OP_END,    8'h00, 8'd1,  1'b1, 7'd64, 1'b1},
            '{OP_SOURCE, 8'hFF, 8'd64, 1'b0, 7'd0,  1'b0},
            '{OP_SOURCE, 8'hFF, 8'd1,  1'b0, 7'd0,  1'b0},  // source full, dropped
            '{OP_END,    8'h00, 8'd1,  1'b1, 7'd0,  1'b1},
            '{OP_SOURCE, 8'h00, 8'd3,  1'b0, 7'd0,  1'b0},
            '{OP_END,    8'h00, 8'd1,  1'b0, 7'd0,  1'b0},
            '{OP_CLEAR,  8'h00, 8'd1,  1'b0, 7'd0,  1'b0},
            '{OP_END,    8'h00, 8'd1,  1'b1, 7'd0,  1'b0}
        };
        tgt_len   = 0;
        drop_seen = 1'b0;
        for (int j = 0; j < MAX_LEN; j++) tgt_chars[j] = '0;
        row_init();

        // reset
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int k = 0; k < DIR_ROWS; k++) begin
            for (int n = 0; n < dir_tab[k].rep; n++) begin
                send_item(dir_tab[k].op, dir_tab[k].ch, dir_tab[k].typed,
                          '{dist_val: dir_tab[k].dist_val, ovf: dir_tab[k].ovf});
            end
        end
        drain_results();

        // random words, mostly well formed, some noise
        while (items_sent < ITEM_GOAL) begin
            r = $urandom_range(0, 99);
            if (r < 14) begin
                // new or extended target
                if ($urandom_range(0, 9) < 7) begin
                    send_item(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), 1'b0, no_res);
                end
                len = pick_len();
                for (int n = 0; n < len; n++) begin
                    send_item(OP_APPEND, pick_char(), 1'b0, no_res);
                end
            end else if (r < 22) begin
                len = $urandom_range(1, 4);
                for (int n = 0; n < len; n++) begin
                    send_item(t_op'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                              1'b0, no_res);
                end
            end else if (r < 24) begin
                drain_results();
            end
            len = pick_len();
            for (int n = 0; n < len; n++) begin
                send_item(OP_SOURCE, pick_char(), 1'b0, no_res);
            end
            send_item(OP_END, CHAR_W'($urandom_range(0, 255)), 1'b0, no_res);
        end

        // let the last results come back
        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/edt_pkg.sv
src/edt_ram.sv
src/edt_cell.sv
src/edit_distance_engine_unit.sv
verif/tb.sv
